/* design/qrs_pkg.sv */
`timescale 1ns / 1ps
package qrs_pkg;
    localparam int CoefW  = 16;
    localparam int ValW   = 32;
    localparam int CodeW  = 3;
    // Square-root operand: |Dq| < 2^33, shifted left by 30.
    localparam int RadW   = 64;
    localparam int RootW  = 32;
    // Division numerator magnitude stays below 2^41.
    localparam int NumW   = 42;
    localparam int DenW   = 16;
    // The rounded quotient can reach 2^32 with a unit divisor, so it needs
    // 33 bits; one more keeps the saturation compare clear of the top.
    localparam int QuoW   = ValW + 2;

    localparam logic [CodeW-1:0] CASE_INVALID    = 3'd0;
    localparam logic [CodeW-1:0] CASE_IMPOSSIBLE = 3'd1;
    localparam logic [CodeW-1:0] CASE_SINGLE     = 3'd2;
    localparam logic [CodeW-1:0] CASE_REAL       = 3'd3;
    localparam logic [CodeW-1:0] CASE_COMPLEX    = 3'd4;
endpackage

/* design/qrs_sqrt_pipe.sv */
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
// Extra data rides alongside in a side vector.
module qrs_sqrt_pipe #(
    parameter int SideW = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [qrs_pkg::RadW-1:0]   in_rad,
    input  logic [SideW-1:0]           in_side,
    output logic                       out_valid,
    output logic [qrs_pkg::RootW-1:0]  out_root,
    output logic [SideW-1:0]           out_side
);
    import qrs_pkg::*;
    localparam int N = RootW;

    logic [N:0]            vld_reg;
    logic [RadW-1:0]       rem_reg  [N+1];
    logic [RootW-1:0]      root_reg [N+1];
    logic [SideW-1:0]      side_reg [N+1];

    always_comb begin
        vld_reg[0]  = in_valid;
        rem_reg[0]  = in_rad;
        root_reg[0] = '0;
        side_reg[0] = in_side;
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam int Sh = 2 * (N - 1 - i);
        logic [RadW-1:0] trial;
        logic [RadW-1:0] cand;
        assign cand  = {{(RadW-RootW-2){1'b0}}, root_reg[i], 2'b01} << Sh;
        assign trial = rem_reg[i] - cand;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
            if (en) begin
                side_reg[i+1] <= side_reg[i];
                if (rem_reg[i] >= cand) begin
                    rem_reg[i+1]  <= trial;
                    root_reg[i+1] <= {root_reg[i][RootW-2:0], 1'b1};
                end else begin
                    rem_reg[i+1]  <= rem_reg[i];
                    root_reg[i+1] <= {root_reg[i][RootW-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign out_root  = root_reg[N];
    assign out_side  = side_reg[N];
endmodule

/* design/qrs_div_pipe.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider of magnitudes, one quotient bit per stage,
// computing floor((2n + d) / 2d), rounded and saturated to Q16.16.
module qrs_div_pipe (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [qrs_pkg::NumW-1:0]   in_num,
    input  logic [qrs_pkg::DenW-1:0]   in_den,
    input  logic                       in_neg,
    output logic [qrs_pkg::ValW-1:0]   out_val,
    output logic                       out_sat
);
    import qrs_pkg::*;
    localparam int N  = QuoW;
    localparam int RW = NumW + 2;

    logic [RW-1:0]   rem_reg [N+1];
    logic [DenW:0]   den_reg [N+1];
    logic [N-1:0]    quo_reg [N+1];
    logic            neg_reg [N+1];

    always_comb begin
        rem_reg[0] = {in_num, 1'b0} + {{(RW-DenW){1'b0}}, in_den};
        den_reg[0] = {in_den, 1'b0};
        quo_reg[0] = '0;
        neg_reg[0] = in_neg;
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam int Sh = N - 1 - i;
        logic [RW+N-1:0] dsh;
        assign dsh = {{(RW+N-DenW-1){1'b0}}, den_reg[i]} << Sh;
        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[i+1] <= den_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                if ({{N{1'b0}}, rem_reg[i]} >= dsh) begin
                    rem_reg[i+1] <= rem_reg[i] - dsh[RW-1:0];
                    quo_reg[i+1] <= quo_reg[i] | (N'(1) << Sh);
                end else begin
                    rem_reg[i+1] <= rem_reg[i];
                    quo_reg[i+1] <= quo_reg[i];
                end
            end
        end
    end

    logic [N-1:0] q;
    assign q = quo_reg[N];
    always_comb begin
        out_sat = 1'b0;
        if (neg_reg[N]) begin
            if (q > N'(64'h8000_0000)) begin
                out_sat = 1'b1;
                out_val = 32'h8000_0000;
            end else begin
                out_val = 32'(-q);
            end
        end else if (q > N'(64'h7FFF_FFFF)) begin
            out_sat = 1'b1;
            out_val = 32'h7FFF_FFFF;
        end else begin
            out_val = q[ValW-1:0];
        end
    end
endmodule

/* design/quadratic_root_solver.sv */
`timescale 1ns / 1ps
// Quadratic root solver: takes a, b and c of a*x^2 + b*x + c in signed Q8.8
// and returns a case code (invalid, impossible, single root, two real roots,
// complex pair) with two signed Q16.16 values and a saturation flag. The
// block is fully pipelined and accepts one beat every cycle while the output
// is not stalled; each beat passes through the three discriminant stages, the
// 32-stage bit-per-stage square root, the 34-stage divider and the output register.
// The whole pipeline advances only when the output register is free or
// being emptied, so a stall on the master side holds every stage.
module quadratic_root_solver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // coef_quad [15:0], coef_lin [31:16], coef_const [47:32]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // case_code [2:0], first_value [34:3], second_value [66:35],
    // saturated [67], zeros [71:68]
    output logic [71:0] m_tdata
);
    import qrs_pkg::*;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Stage 1: products.
    logic               v1_reg;
    logic signed [15:0] a1_reg, b1_reg, c1_reg;
    logic signed [32:0] bb1_reg, ac1_reg;
    // Stage 2: discriminant.
    logic               v2_reg;
    logic signed [15:0] a2_reg, b2_reg, c2_reg;
    logic signed [34:0] dq2_reg;
    // Stage 3: radicand.
    logic               v3_reg;
    logic [RadW-1:0]    rad3_reg;
    localparam int SideW = 3 * CoefW + 1;
    logic [SideW-1:0]   side3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        if (en) begin
            a1_reg  <= s_tdata[15:0];
            b1_reg  <= s_tdata[31:16];
            c1_reg  <= s_tdata[47:32];
            bb1_reg <= 33'($signed(s_tdata[31:16]) * $signed(s_tdata[31:16]));
            ac1_reg <= 33'($signed(s_tdata[15:0]) * $signed(s_tdata[47:32]));
            a2_reg  <= a1_reg;
            b2_reg  <= b1_reg;
            c2_reg  <= c1_reg;
            dq2_reg <= 35'(bb1_reg) - (35'(ac1_reg) <<< 2);
            rad3_reg <= RadW'(dq2_reg[34] ? 35'(-dq2_reg) : dq2_reg) << 30;
            side3_reg <= {dq2_reg[34], c2_reg, b2_reg, a2_reg};
        end
    end

    logic             v4;
    logic [RootW-1:0] r4;
    logic [SideW-1:0] side4;
    qrs_sqrt_pipe #(.SideW(SideW)) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v3_reg), .in_rad(rad3_reg), .in_side(side3_reg),
        .out_valid(v4), .out_root(r4), .out_side(side4)
    );

    // Numerator and case selection feeding both dividers.
    logic signed [15:0] a4, b4, c4;
    logic               dneg4;
    assign a4    = side4[15:0];
    assign b4    = side4[31:16];
    assign c4    = side4[47:32];
    assign dneg4 = side4[48];

    logic [CodeW-1:0]   code4;
    logic signed [NumW-1:0] n1, n2, base;
    logic signed [16:0] den;
    always_comb begin
        base = NumW'(-(NumW'(b4) <<< 15));
        n1 = '0;
        n2 = '0;
        den = 17'sd1;
        if (a4 == 16'sd0) begin
            den = 17'(b4);
            if (b4 == 16'sd0) begin
                code4 = (c4 == 16'sd0) ? CASE_INVALID : CASE_IMPOSSIBLE;
                den = 17'sd1;
            end else begin
                code4 = CASE_SINGLE;
                n1 = NumW'(-(NumW'(c4) <<< 16));
            end
        end else begin
            den = 17'(a4);
            if (!dneg4) begin
                code4 = CASE_REAL;
                n1 = base + NumW'(r4);
                n2 = base - NumW'(r4);
            end else begin
                code4 = CASE_COMPLEX;
                n1 = base;
                n2 = NumW'(r4);
            end
        end
    end

    logic [NumW-1:0] m1, m2;
    logic [DenW-1:0] md;
    assign m1 = n1[NumW-1] ? NumW'(-n1) : n1;
    assign m2 = n2[NumW-1] ? NumW'(-n2) : n2;
    assign md = DenW'(den[16] ? -den : den);

    logic [ValW-1:0] q1, q2;
    logic            s1, s2;
    qrs_div_pipe u_div1 (
        .aclk(aclk), .en(en), .in_num(m1), .in_den(md),
        .in_neg((n1[NumW-1] != den[16]) && (n1 != '0)),
        .out_val(q1), .out_sat(s1)
    );
    qrs_div_pipe u_div2 (
        .aclk(aclk), .en(en), .in_num(m2), .in_den(md),
        .in_neg((n2[NumW-1] != den[16]) && (n2 != '0)),
        .out_val(q2), .out_sat(s2)
    );

    // Code, validity and which values are live travel beside the dividers.
    localparam int DivN = QuoW;
    logic [DivN:0]   dv_reg;
    logic [CodeW-1:0] dc_reg [DivN+1];
    always_comb begin
        dv_reg[0] = v4;
        dc_reg[0] = code4;
    end
    for (genvar i = 0; i < DivN; i++) begin : g_side
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[i+1] <= 1'b0;
            end else if (en) begin
                dv_reg[i+1] <= dv_reg[i];
            end
            if (en) begin
                dc_reg[i+1] <= dc_reg[i];
            end
        end
    end

    logic [CodeW-1:0] oc;
    logic             use1, use2;
    assign oc   = dc_reg[DivN];
    assign use1 = (oc == CASE_SINGLE) || (oc == CASE_REAL) || (oc == CASE_COMPLEX);
    assign use2 = (oc == CASE_REAL) || (oc == CASE_COMPLEX);

    // Output register.
    logic        ov_reg;
    logic [71:0] od_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (en) begin
            ov_reg <= dv_reg[DivN];
        end
        if (en) begin
            od_reg <= {4'b0, (use1 && s1) || (use2 && s2),
                       use2 ? q2 : 32'b0, use1 ? q1 : 32'b0, oc};
        end
    end
    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
module tb;
    import qrs_pkg::*;

    localparam int Latency = 70;
    localparam longint CycleLimit = 400000;

    typedef struct packed {
        logic [CodeW-1:0] case_code;
        logic [31:0]      first_value;
        logic [31:0]      second_value;
        logic             saturated;
    } roots_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    roots_t expected_roots[$];
    int     error_count = 0;
    longint cycle_count = 0;
    // When set, the sink never stalls (a long stretch without idling).
    bit     sink_eager = 1'b0;
    bit     source_eager = 1'b0;

    quadratic_root_solver dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic longint isqrt(input longint unsigned x);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Rounded division (ties away from zero), clipped to the Q16.16 range.
    function automatic logic [31:0] round_div(input longint num, input longint den,
                                              inout logic clipped);
        longint unsigned un, ud, q;
        logic neg;
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        q = (2 * un + ud) / (2 * ud);
        neg = (num < 0) != (den < 0);
        if (neg) begin
            if (q > 64'd2147483648) begin
                clipped = 1'b1;
                return 32'h8000_0000;
            end
            return 32'(-q);
        end
        if (q > 64'd2147483647) begin
            clipped = 1'b1;
            return 32'h7fff_ffff;
        end
        return 32'(q);
    endfunction

    function automatic roots_t solve_quadratic(input logic signed [15:0] qa,
                                               input logic signed [15:0] qb,
                                               input logic signed [15:0] qc);
        roots_t r;
        longint a, b, c, disc, root, base;
        a = qa;
        b = qb;
        c = qc;
        r = '0;
        if (a == 0) begin
            if (b == 0) begin
                r.case_code = (c == 0) ? CASE_INVALID : CASE_IMPOSSIBLE;
            end else begin
                r.case_code = CASE_SINGLE;
                r.first_value = round_div(-c * 65536, b, r.saturated);
            end
        end else begin
            disc = b * b - 4 * a * c;
            root = isqrt((disc < 0 ? -disc : disc) << 30);
            base = -b * 32768;
            if (disc >= 0) begin
                r.case_code = CASE_REAL;
                r.first_value = round_div(base + root, a, r.saturated);
                r.second_value = round_div(base - root, a, r.saturated);
            end else begin
                r.case_code = CASE_COMPLEX;
                r.first_value = round_div(base, a, r.saturated);
                r.second_value = round_div(root, a, r.saturated);
            end
        end
        return r;
    endfunction

    // Sends one coefficient set; the expectation is queued at acceptance.
    // The valid line is left high so the next beat can follow at once.
    task automatic send_coefs(input logic [15:0] qa, input logic [15:0] qb,
                              input logic [15:0] qc);
        while (!source_eager && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {qc, qb, qa};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_roots.push_back(solve_quadratic(qa, qb, qc));
        @(negedge aclk);
    endtask

    // Sink: stalls at random, checks every accepted beat against the oldest expectation.
    always @(negedge aclk) begin
        m_tready <= aresetn && (sink_eager || $urandom_range(99) >= 29);
    end

    always @(posedge aclk) begin
        roots_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[2:0], m_tdata[34:3], m_tdata[66:35], m_tdata[67]};
            if (expected_roots.size() == 0) begin
                report_mismatch("unexpected beat", got.case_code, -1);
            end else begin
                want = expected_roots.pop_front();
                if (got.case_code != want.case_code)
                    report_mismatch("case_code", got.case_code, want.case_code);
                if (got.first_value != want.first_value)
                    report_mismatch("first_value", $signed(got.first_value),
                                    $signed(want.first_value));
                if (got.second_value != want.second_value)
                    report_mismatch("second_value", $signed(got.second_value),
                                    $signed(want.second_value));
                if (got.saturated != want.saturated)
                    report_mismatch("saturated", got.saturated, want.saturated);
            end
        end
    end

    task automatic test_directed_cases();
        send_coefs(16'h0000, 16'h0000, 16'h0000);   // invalid equation
        send_coefs(16'h0000, 16'h0000, 16'h0100);   // impossible equation
        send_coefs(16'h0000, 16'h0000, 16'h8000);
        send_coefs(16'h0000, 16'h0100, 16'h0200);   // single root
        send_coefs(16'h0000, 16'h0001, 16'h8000);   // single root that overflows
        send_coefs(16'h0000, 16'hffff, 16'h8000);
        send_coefs(16'h0000, 16'h7fff, 16'h7fff);
        send_coefs(16'h0100, 16'h0000, 16'hff00);   // two real roots
        send_coefs(16'h0100, 16'h0200, 16'h0100);   // double root
        send_coefs(16'h0100, 16'h0000, 16'h0100);   // complex pair
        send_coefs(16'hff00, 16'h0000, 16'hff00);   // complex pair, negative a
        send_coefs(16'h0001, 16'h7fff, 16'h0000);
        send_coefs(16'h0001, 16'h8000, 16'h7fff);
        send_coefs(16'h8000, 16'h8000, 16'h8000);
        send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
        send_coefs(16'h8000, 16'h7fff, 16'h7fff);
        send_coefs(16'hffff, 16'h0001, 16'hffff);
        send_coefs(16'h0001, 16'h0000, 16'h8000);
        send_coefs(16'h0001, 16'h0000, 16'h7fff);
    endtask

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return {{8{$urandom_range(1) == 1}}, 8'($urandom)};
            2: return 16'($urandom_range(1) ? 16'h7fff : 16'h8000);
            3: return 16'($signed(16'($urandom_range(15))) - 8) << 8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_random_sets(input int count);
        logic [15:0] qa;
        for (int i = 0; i < count; i++) begin
            sink_eager = (i >= count / 2) && (i < count / 2 + 150);
            source_eager = sink_eager;
            // Zero a often enough to cover the linear cases well.
            qa = ($urandom_range(4) == 0) ? 16'h0000 : pick_coef();
            send_coefs(qa, pick_coef(), pick_coef());
        end
        sink_eager = 1'b0;
        source_eager = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_cases();
        test_random_sets(1200);
        s_tvalid <= 1'b0;
        while (expected_roots.size() != 0) @(posedge aclk);
        repeat (Latency + 10) @(posedge aclk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
